// ----- design/multichannel_overwrite_ring_buffer_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel overwrite ring buffer
// Concurrent assertion wrappers, with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_OVERWRITE_RING_BUFFER_MACROS_SVH
`define MULTICHANNEL_OVERWRITE_RING_BUFFER_MACROS_SVH

// property checked only while reset is released
`define MOR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every edge, reset included
`define MOR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/mor_pkg.sv -----
// ----------------------------------------------------------------------------
// mor_pkg
// Shared widths, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mor_pkg;

    localparam int FUNC_W = 2;
    localparam int CH_W   = 3;
    localparam int SMP_W  = 32;
    localparam int OFF_W  = 10;
    localparam int CAP_W  = 11;
    localparam int CNT_W  = 11;

    localparam int S_TDATA_W = 48;   // sample_in, offset, zero pad
    localparam int S_TUSER_W = 5;    // func, channel
    localparam int M_TDATA_W = 56;   // sample_out, unread, history, zero pad
    localparam int M_TUSER_W = 2;    // is_full, offset_error

    localparam int CHAN_COUNT_DEF = 8;
    localparam int MAX_DEPTH_DEF  = 1024;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    localparam logic [FUNC_W-1:0] FUNC_PUSH        = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP         = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK_AHEAD  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_PEEK_BEHIND = 2'd3;

    typedef struct packed {
        logic clr_we;     // write zero at the clear pointer
        logic load;       // capture input beat and channel state
        logic mod_start;  // launch index reduction
        logic mod_sel;    // 0: read index, 1: write index
        logic access;     // memory access and state commit
        logic out_load;   // move result into output register
    } mor_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic mod_done;
        logic out_busy;
    } mor_status_t;

endpackage

// ----- design/mor_mod.sv -----
// ----------------------------------------------------------------------------
// mor_mod
// Iterative remainder unit: one restoring step per cycle, with a fast path,
// done in the cycle after start, when the dividend is below the divisor.
// ----------------------------------------------------------------------------
module mor_mod #(
    parameter int MAX_DEPTH = mor_pkg::MAX_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [$clog2(MAX_DEPTH)-1:0]  dividend,
    input  logic [mor_pkg::CAP_W-1:0]     divisor,
    output logic                          done,
    output logic [$clog2(MAX_DEPTH)-1:0]  rem
);
    import mor_pkg::*;

    localparam int IW   = $clog2(MAX_DEPTH);
    localparam int RW   = CAP_W + 1;
    localparam int CNTW = $clog2(IW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [IW-1:0]   sh_reg;
    logic [RW-1:0]   rem_reg;
    logic [RW-1:0]   trial;
    logic [RW-1:0]   step_rem;
    logic            fast;

    always_comb begin
        trial    = {rem_reg[RW-2:0], sh_reg[IW-1]};
        step_rem = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
        fast     = 32'(dividend) < 32'(divisor);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= (start && fast) ||
                        (!start && busy_reg && (cnt_reg == CNTW'(1)));
            if (start) begin
                if (!fast) begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNTW'(IW);
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sh_reg  <= dividend;
            // fast path: dividend is below divisor, so it fits
            rem_reg <= fast ? RW'(dividend) : '0;
        end else if (busy_reg) begin
            sh_reg  <= sh_reg << 1;
            rem_reg <= step_rem;
        end
    end

    assign done = done_reg;
    assign rem  = IW'(rem_reg);

endmodule

// ----- design/mor_ctrl.sv -----
// ----------------------------------------------------------------------------
// mor_ctrl
// Sequencer: memory clear after reset, then one operation at a time through
// index reduction, memory access and result hand-off.
// ----------------------------------------------------------------------------
module mor_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  mor_pkg::mor_status_t status,
    output mor_pkg::mor_cmd_t    cmd
);
    import mor_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MODR_S = 3'd2;
    localparam logic [2:0] ST_MODR_W = 3'd3;
    localparam logic [2:0] ST_MODW_S = 3'd4;
    localparam logic [2:0] ST_MODW_W = 3'd5;
    localparam logic [2:0] ST_ACCESS = 3'd6;
    localparam logic [2:0] ST_RESULT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MODR_S;
                end
            end
            ST_MODR_S: begin
                cmd.mod_start = 1'b1;
                state_next    = ST_MODR_W;
            end
            ST_MODR_W: begin
                if (status.mod_done) begin
                    state_next = ST_MODW_S;
                end
            end
            ST_MODW_S: begin
                cmd.mod_sel   = 1'b1;
                cmd.mod_start = 1'b1;
                state_next    = ST_MODW_W;
            end
            ST_MODW_W: begin
                cmd.mod_sel = 1'b1;
                if (status.mod_done) begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                cmd.access = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                // wait for the output register to drain
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/mor_datapath.sv -----
// ----------------------------------------------------------------------------
// mor_datapath
// Sample memory, per-channel index state, index arithmetic, capacity
// register and the output register.
// ----------------------------------------------------------------------------
module mor_datapath #(
    parameter int CHAN_COUNT = mor_pkg::CHAN_COUNT_DEF,
    parameter int MAX_DEPTH  = mor_pkg::MAX_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mor_pkg::mor_cmd_t             cmd,
    output mor_pkg::mor_status_t          status,
    input  logic [mor_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [mor_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          cfg_wr_en,
    input  logic [mor_pkg::CAP_W-1:0]     cfg_wr_data,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [mor_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [mor_pkg::M_TUSER_W-1:0] m_tuser
);
    import mor_pkg::*;

    localparam int IW    = $clog2(MAX_DEPTH);
    localparam int CW    = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;
    localparam int DEPTH = CHAN_COUNT * MAX_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = ((IW > CAP_W) ? IW : CAP_W) + 1;

    // input beat
    logic [FUNC_W-1:0] in_func;
    logic [CH_W-1:0]   in_ch;
    logic [SMP_W-1:0]  in_smp;
    logic [OFF_W-1:0]  in_off;
    logic              in_ch_ok;
    logic [CW-1:0]     in_ch_idx;

    assign in_func   = s_tuser[1:0];
    assign in_ch     = s_tuser[4:2];
    assign in_smp    = s_tdata[31:0];
    assign in_off    = s_tdata[41:32];
    assign in_ch_ok  = 32'(in_ch) < CHAN_COUNT;
    assign in_ch_idx = CW'(in_ch);

    // capacity register and its clamp
    logic [CAP_W-1:0] capacity_reg;
    logic [CAP_W-1:0] cap_lo;
    logic [CAP_W-1:0] eff_cap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        cap_lo  = (capacity_reg == '0) ? CAP_W'(1) : capacity_reg;
        eff_cap = (32'(cap_lo) > MAX_DEPTH) ? CAP_W'(MAX_DEPTH) : cap_lo;
    end

    // per-channel state
    logic [IW-1:0]    rd_idx_reg [CHAN_COUNT];
    logic [IW-1:0]    wr_idx_reg [CHAN_COUNT];
    logic             full_reg   [CHAN_COUNT];
    logic [CNT_W-1:0] vcnt_reg   [CHAN_COUNT];

    // working copy of the operation
    logic [FUNC_W-1:0] func_reg;
    logic              ch_ok_reg;
    logic [CW-1:0]     ch_idx_reg;
    logic [SMP_W-1:0]  smp_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [IW-1:0]     rd_raw_reg;
    logic [IW-1:0]     wr_raw_reg;
    logic              full_w_reg;
    logic [CNT_W-1:0]  vcnt_w_reg;
    logic [IW-1:0]     rm_reg;
    logic [IW-1:0]     wm_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg   <= in_func;
            ch_ok_reg  <= in_ch_ok;
            ch_idx_reg <= in_ch_idx;
            smp_reg    <= in_smp;
            off_reg    <= in_off;
            cap_reg    <= eff_cap;
            rd_raw_reg <= in_ch_ok ? rd_idx_reg[in_ch_idx] : '0;
            wr_raw_reg <= in_ch_ok ? wr_idx_reg[in_ch_idx] : '0;
            full_w_reg <= in_ch_ok ? full_reg[in_ch_idx] : 1'b0;
            vcnt_w_reg <= in_ch_ok ? vcnt_reg[in_ch_idx] : '0;
        end
    end

    // index reduction mod capacity
    logic [IW-1:0] mod_rem;
    logic          mod_done;

    mor_mod #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.mod_start),
        .dividend (cmd.mod_sel ? wr_raw_reg : rd_raw_reg),
        .divisor  (cap_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_ff @(posedge aclk) begin
        if (mod_done) begin
            if (cmd.mod_sel) begin
                wm_reg <= mod_rem;
            end else begin
                rm_reg <= mod_rem;
            end
        end
    end

    // operation arithmetic
    logic [SW-1:0]    cap_s;
    logic [SW-1:0]    off_s;
    logic [IW-1:0]    rm_inc;
    logic [IW-1:0]    wm_inc;
    logic [SW-1:0]    pos_sum;
    logic [IW-1:0]    pos;
    logic [IW-1:0]    rd_new;
    logic [IW-1:0]    wr_new;
    logic [IW-1:0]    rm_new;
    logic [IW-1:0]    wm_new;
    logic             full_new;
    logic [CNT_W-1:0] vcnt_new;
    logic             commit;
    logic             so_en;
    logic             err;
    logic [IW-1:0]    mem_idx;
    logic [SW-1:0]    diff;
    logic [CNT_W-1:0] avail;
    logic [CNT_W-1:0] hist;

    always_comb begin
        cap_s  = SW'(cap_reg);
        off_s  = SW'(off_reg);
        rm_inc = (SW'(rm_reg) + SW'(1) == cap_s) ? '0 : IW'(SW'(rm_reg) + SW'(1));
        wm_inc = (SW'(wm_reg) + SW'(1) == cap_s) ? '0 : IW'(SW'(wm_reg) + SW'(1));
        err    = 1'b0;

        if (func_reg == FUNC_PEEK_AHEAD) begin
            pos_sum = SW'(rm_reg) + off_s;
        end else begin
            pos_sum = SW'(rm_reg) + cap_s - off_s;
        end
        pos = (pos_sum >= cap_s) ? IW'(pos_sum - cap_s) : IW'(pos_sum);

        unique case (func_reg)
            FUNC_PUSH: begin
                wr_new   = wm_inc;
                rd_new   = full_w_reg ? wm_inc : rd_raw_reg;
                rm_new   = full_w_reg ? wm_inc : rm_reg;
                wm_new   = wm_inc;
                full_new = (wm_inc == rd_new);
                vcnt_new = (!full_w_reg && (vcnt_w_reg < cap_reg)) ?
                           vcnt_w_reg + 1'b1 : vcnt_w_reg;
                commit   = ch_ok_reg;
                so_en    = 1'b0;
                mem_idx  = wr_raw_reg;
            end
            FUNC_POP: begin
                wr_new   = wr_raw_reg;
                rd_new   = rm_inc;
                rm_new   = rm_inc;
                wm_new   = wm_reg;
                full_new = 1'b0;
                vcnt_new = vcnt_w_reg;
                commit   = ch_ok_reg;
                so_en    = 1'b1;
                mem_idx  = rd_raw_reg;
            end
            FUNC_PEEK_AHEAD, FUNC_PEEK_BEHIND: begin
                wr_new   = wr_raw_reg;
                rd_new   = rd_raw_reg;
                rm_new   = rm_reg;
                wm_new   = wm_reg;
                full_new = full_w_reg;
                vcnt_new = vcnt_w_reg;
                commit   = 1'b0;
                err      = (SW'(off_reg) >= cap_s);
                so_en    = !err;
                mem_idx  = err ? '0 : pos;
            end
        endcase

        diff  = SW'(wm_new) + cap_s - SW'(rm_new);
        avail = full_new ? cap_reg :
                ((diff >= cap_s) ? CNT_W'(diff - cap_s) : CNT_W'(diff));
        hist  = (vcnt_new > avail) ? vcnt_new - avail : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHAN_COUNT; i++) begin
                rd_idx_reg[i] <= '0;
                wr_idx_reg[i] <= '0;
                full_reg[i]   <= 1'b0;
                vcnt_reg[i]   <= '0;
            end
        end else if (cmd.access && commit) begin
            rd_idx_reg[ch_idx_reg] <= rd_new;
            wr_idx_reg[ch_idx_reg] <= wr_new;
            full_reg[ch_idx_reg]   <= full_new;
            vcnt_reg[ch_idx_reg]   <= vcnt_new;
        end
    end

    // sample memory with clear sweep
    logic [SMP_W-1:0] mem [DEPTH];
    logic [SMP_W-1:0] mem_rdata_reg;
    logic [AW-1:0]    clr_cnt_reg;
    logic             clr_last;
    logic [AW-1:0]    acc_addr;
    logic [AW-1:0]    wr_addr;
    logic             mem_we;
    logic [SMP_W-1:0] wr_data;

    always_comb begin
        clr_last = (clr_cnt_reg == AW'(DEPTH - 1));
        acc_addr = ch_ok_reg ? AW'(32'(ch_idx_reg) * MAX_DEPTH + 32'(mem_idx)) : '0;
        wr_addr  = cmd.clr_we ? clr_cnt_reg : acc_addr;
        wr_data  = cmd.clr_we ? '0 : smp_reg;
        mem_we   = cmd.clr_we || (cmd.access && commit && (func_reg == FUNC_PUSH));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_we) begin
            clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.access) begin
            mem_rdata_reg <= mem[acc_addr];
        end
    end

    // result staging, then output register
    logic             res_so_en_reg;
    logic [CNT_W-1:0] res_avail_reg;
    logic [CNT_W-1:0] res_hist_reg;
    logic             res_full_reg;
    logic             res_err_reg;

    always_ff @(posedge aclk) begin
        if (cmd.access) begin
            res_so_en_reg <= ch_ok_reg && so_en;
            res_avail_reg <= ch_ok_reg ? avail : '0;
            res_hist_reg  <= ch_ok_reg ? hist : '0;
            res_full_reg  <= ch_ok_reg && full_new;
            res_err_reg   <= ch_ok_reg && err;
        end
    end

    logic             out_valid_reg;
    logic [SMP_W-1:0] out_smp_reg;
    logic [CNT_W-1:0] out_avail_reg;
    logic [CNT_W-1:0] out_hist_reg;
    logic             out_full_reg;
    logic             out_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_smp_reg   <= res_so_en_reg ? mem_rdata_reg : '0;
            out_avail_reg <= res_avail_reg;
            out_hist_reg  <= res_hist_reg;
            out_full_reg  <= res_full_reg;
            out_err_reg   <= res_err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_hist_reg, out_avail_reg, out_smp_reg};
    assign m_tuser  = {out_err_reg, out_full_reg};

    assign status.clr_last = clr_last;
    assign status.mod_done = mod_done;
    assign status.out_busy = out_valid_reg && !m_tready;

endmodule

// ----- design/multichannel_overwrite_ring_buffer.sv -----
// After an input beat the read index and then the write index are reduced
// mod capacity in the shared remainder unit, each by the restoring path when
// at or above capacity; the memory is then accessed and the result loaded
// into the output register once it is free; only then is a new beat taken.
// After reset, with s_tready low and configuration writes taken, the memory
// is zeroed one word per cycle, CHAN_COUNT*MAX_DEPTH words, 8192 by default.
// ----------------------------------------------------------------------------
// multichannel_overwrite_ring_buffer
// Per-channel circular sample store with overwrite on full, push, pop and
// peek operations over a stream interface.
// ----------------------------------------------------------------------------
module multichannel_overwrite_ring_buffer #(
    parameter int CHAN_COUNT = mor_pkg::CHAN_COUNT_DEF,
    parameter int MAX_DEPTH  = mor_pkg::MAX_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mor_pkg::S_TDATA_W-1:0] s_tdata,     // sample_in, offset
    input  logic [mor_pkg::S_TUSER_W-1:0] s_tuser,     // func, channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mor_pkg::M_TDATA_W-1:0] m_tdata,     // sample_out, unread_count,
                                                       // history_count
    output logic [mor_pkg::M_TUSER_W-1:0] m_tuser,     // is_full, offset_error
    input  logic                          cfg_wr_en,
    input  logic [mor_pkg::CAP_W-1:0]     cfg_wr_data  // capacity
);
    import mor_pkg::*;

    mor_cmd_t    cmd;
    mor_status_t status;

    mor_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mor_datapath #(
        .CHAN_COUNT (CHAN_COUNT),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ----- design/mor_chk.sv -----
// ----------------------------------------------------------------------------
// mor_chk
// Port-level checks for the ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "multichannel_overwrite_ring_buffer_macros.svh"

module mor_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mor_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [mor_pkg::M_TUSER_W-1:0] m_tuser
);
    import mor_pkg::*;

    // reset leaves no result pending and holds off input during the clear sweep
    `MOR_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !s_tready && !m_tvalid, "reset not quiet")

    // one operation in flight
    `MOR_ASSERT(a_single_op, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second beat taken")

    // a rejected peek returns a zero sample
    `MOR_ASSERT(a_err_zero, aclk, aresetn, m_tvalid && m_tuser[1] |-> m_tdata[31:0] == 32'd0, "offset error with data")

    `MOR_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind multichannel_overwrite_ring_buffer mor_chk u_mor_chk (.*);

// ----- tb/tb_multichannel_overwrite_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// Testbench for multichannel_overwrite_ring_buffer
// Drives push, pop and peek beats over the stream ports with random gaps and
// output stalls. It steps the capacity register through small, clamped and
// extreme values. A scoreboard keeps its own copy of every channel ring,
// predicts each readout and checks the result beats in order.
// ----------------------------------------------------------------------------
module tb_multichannel_overwrite_ring_buffer;
    timeunit 1ns;
    timeprecision 1ps;

    import mor_pkg::*;

    localparam int CHANNELS    = CHAN_COUNT_DEF;
    localparam int DEPTH       = MAX_DEPTH_DEF;
    localparam int SETTLE      = 40;       // drain margin, above the worst-case latency
    localparam int CYCLE_LIMIT = 500000;

    // ------------------------------------------------------------------------
    // Ring model and readout checker
    // ------------------------------------------------------------------------
    class ring_checker;
        typedef struct {
            logic [SMP_W-1:0] sample;
            logic [CNT_W-1:0] unread;
            logic [CNT_W-1:0] history;
            logic             full;
            logic             off_err;
        } readout_t;

        logic [SMP_W-1:0] samples[CHANNELS*DEPTH];
        int               rd_idx[CHANNELS];
        int               wr_idx[CHANNELS];
        bit               full_q[CHANNELS];
        int               valid_q[CHANNELS];
        logic [CAP_W-1:0] cap_reg;
        readout_t         readouts_due[$];
        int               mismatches;
        int               checked;

        function new();
            foreach (samples[i]) samples[i] = '0;
            foreach (rd_idx[i]) begin
                rd_idx[i]  = 0;
                wr_idx[i]  = 0;
                full_q[i]  = 0;
                valid_q[i] = 0;
            end
            cap_reg    = CAP_RESET;
            mismatches = 0;
            checked    = 0;
        endfunction

        function int eff_cap();
            int c;
            c = int'(cap_reg);
            if (c < 1) c = 1;
            if (c > DEPTH) c = DEPTH;
            return c;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] v);
            cap_reg = v;
        endfunction

        function int pending();
            return readouts_due.size();
        endfunction

        function void note_command(logic [FUNC_W-1:0] fn, logic [CH_W-1:0] ch,
                                   logic [SMP_W-1:0] smp, logic [OFF_W-1:0] off);
            int       cap;
            int       c;
            int       pos;
            int       avail;
            readout_t r;
            cap = eff_cap();
            c   = int'(ch);
            r   = '{default: '0};
            case (fn)
                FUNC_PUSH: begin
                    samples[c*DEPTH + (wr_idx[c] % DEPTH)] = smp;
                    wr_idx[c] = (wr_idx[c] + 1) % cap;
                    if (full_q[c]) begin
                        rd_idx[c] = wr_idx[c];
                    end else if (valid_q[c] < cap) begin
                        valid_q[c]++;
                    end
                    full_q[c] = (wr_idx[c] == rd_idx[c]);
                end
                FUNC_POP: begin
                    r.sample  = samples[c*DEPTH + (rd_idx[c] % DEPTH)];
                    rd_idx[c] = (rd_idx[c] + 1) % cap;
                    full_q[c] = 0;
                end
                default: begin
                    if (int'(off) >= cap) begin
                        r.off_err = 1'b1;
                    end else begin
                        if (fn == FUNC_PEEK_AHEAD)
                            pos = (rd_idx[c] % cap + int'(off)) % cap;
                        else
                            pos = (rd_idx[c] % cap + cap - int'(off)) % cap;
                        r.sample = samples[c*DEPTH + pos];
                    end
                end
            endcase
            if (full_q[c])
                avail = cap;
            else
                avail = (wr_idx[c] % cap + cap - rd_idx[c] % cap) % cap;
            r.unread  = CNT_W'(avail);
            r.history = (valid_q[c] > avail) ? CNT_W'(valid_q[c] - avail) : '0;
            r.full    = full_q[c];
            readouts_due.push_back(r);
        endfunction

        task report_mismatch(string what, logic [SMP_W-1:0] got,
                             logic [SMP_W-1:0] want);
            if (mismatches < 50)
                $display("mismatch at result %0d: %s got %h want %h",
                         checked, what, got, want);
            mismatches++;
        endtask

        task check_readout(logic [M_TDATA_W-1:0] td, logic [M_TUSER_W-1:0] tu);
            readout_t r;
            if (readouts_due.size() == 0) begin
                report_mismatch("unexpected beat, tdata[31:0]", td[31:0], '0);
            end else begin
                r = readouts_due.pop_front();
                if (td[31:0] !== r.sample)
                    report_mismatch("sample_out", td[31:0], r.sample);
                if (td[42:32] !== r.unread)
                    report_mismatch("unread_count", 32'(td[42:32]), 32'(r.unread));
                if (td[53:43] !== r.history)
                    report_mismatch("history_count", 32'(td[53:43]), 32'(r.history));
                if (td[55:54] !== 2'b00)
                    report_mismatch("tdata pad", 32'(td[55:54]), '0);
                if (tu[0] !== r.full)
                    report_mismatch("is_full", 32'(tu[0]), 32'(r.full));
                if (tu[1] !== r.off_err)
                    report_mismatch("offset_error", 32'(tu[1]), 32'(r.off_err));
            end
            checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // sample_in, offset
    logic [S_TUSER_W-1:0] s_tuser;   // func, channel
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // sample_out, unread_count, history_count
    logic [M_TUSER_W-1:0] m_tuser;   // is_full, offset_error
    logic                 cfg_wr_en;
    logic [CAP_W-1:0]     cfg_wr_data;

    ring_checker board;
    bit          quiet;
    int          cycles;

    multichannel_overwrite_ring_buffer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls, one assignment of m_tready per edge
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                board.check_readout(m_tdata, m_tuser);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                m_tready <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    task automatic send_beat(logic [FUNC_W-1:0] fn, logic [CH_W-1:0] ch,
                             logic [SMP_W-1:0] smp, logic [OFF_W-1:0] off);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, off, smp};
        s_tuser  <= {ch, fn};
        do @(posedge aclk); while (!s_tready);
        board.note_command(fn, ch, smp, off);
    endtask

    // wait for the ring to drain and settle before touching the register
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        board.set_capacity(v);
    endtask

    task automatic random_phase(int count);
        int               cap;
        int               r;
        logic [CH_W-1:0]  hot;
        logic [CH_W-1:0]  ch;
        logic [FUNC_W-1:0] fn;
        logic [OFF_W-1:0] off;
        cap = board.eff_cap();
        hot = CH_W'($urandom_range(0, CHANNELS-1));
        repeat (count) begin
            r  = $urandom_range(0, 99);
            fn = (r < 40) ? FUNC_PUSH :
                 (r < 65) ? FUNC_POP :
                 (r < 83) ? FUNC_PEEK_AHEAD : FUNC_PEEK_BEHIND;
            ch = ($urandom_range(0, 9) < 7) ? hot : CH_W'($urandom_range(0, CHANNELS-1));
            if ($urandom_range(0, 9) < 7)
                off = OFF_W'($urandom_range(0, (cap > 1023) ? 1023 : cap));
            else
                off = OFF_W'($urandom);
            send_beat(fn, ch, $urandom, off);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [CAP_W-1:0] caps[14];
        board       = new();
        quiet       = 1'b0;
        cycles      = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        caps = '{11'd3, 11'd1, 11'd0, 11'd2, 11'd5, 11'd2047, 11'd8,
                 11'd1024, 11'd4, 11'd16, 11'd7, 11'd1, 11'd12, 11'd600};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at the reset capacity
        send_beat(FUNC_POP,         3'd0, 32'h1234_5678, 10'd0);   // pop on empty
        send_beat(FUNC_PUSH,        3'd1, 32'h0000_0000, 10'h3FF);
        send_beat(FUNC_PUSH,        3'd1, 32'hFFFF_FFFF, 10'd0);
        send_beat(FUNC_PUSH,        3'd7, 32'hA5A5_A5A5, 10'd5);
        send_beat(FUNC_PEEK_AHEAD,  3'd1, 32'hFFFF_FFFF, 10'd0);
        send_beat(FUNC_PEEK_AHEAD,  3'd1, 32'h0,         10'd1);
        send_beat(FUNC_PEEK_AHEAD,  3'd1, 32'h0,         10'd1023);
        send_beat(FUNC_PEEK_BEHIND, 3'd1, 32'h0,         10'd1);   // wraps
        send_beat(FUNC_PEEK_BEHIND, 3'd1, 32'h0,         10'd1023);
        send_beat(FUNC_POP,         3'd1, 32'h0,         10'h2AA);
        send_beat(FUNC_POP,         3'd1, 32'h0,         10'h155);
        send_beat(FUNC_POP,         3'd1, 32'h0,         10'd0);   // past empty

        // shrink: indices left at and above capacity, offsets at and over capacity
        write_capacity(11'd2);
        send_beat(FUNC_PEEK_AHEAD,  3'd1, 32'h0,         10'd2);
        send_beat(FUNC_PEEK_BEHIND, 3'd1, 32'h0,         10'd1023);
        send_beat(FUNC_PEEK_AHEAD,  3'd1, 32'h0,         10'd1);
        send_beat(FUNC_PUSH,        3'd7, 32'h8000_0001, 10'd0);
        send_beat(FUNC_PUSH,        3'd7, 32'h7FFF_FFFE, 10'd0);
        send_beat(FUNC_PUSH,        3'd7, 32'hDEAD_BEEF, 10'd0);   // overwrite on full
        send_beat(FUNC_PEEK_BEHIND, 3'd7, 32'h0,         10'd1);
        send_beat(FUNC_POP,         3'd7, 32'h0,         10'd0);
        send_beat(FUNC_PUSH,        3'd6, 32'h5555_AAAA, 10'd0);
        send_beat(FUNC_POP,         3'd6, 32'h0,         10'd0);

        foreach (caps[i]) begin
            write_capacity(caps[i]);
            quiet = (i % 4 == 3);
            random_phase(45);
        end
        quiet = 1'b0;

        drain();
        if (board.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
